// ----- hw/rtl/ptscan_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptscan_pkg
// Shared types and constants of the pan/tilt drive controller.
// ----------------------------------------------------------------------------
package ptscan_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MAX_SPEED     = 3'd0;
  localparam logic [2:0] REG_POS_KP        = 3'd1;
  localparam logic [2:0] REG_POS_KD        = 3'd2;
  localparam logic [2:0] REG_VEL_KP        = 3'd3;
  localparam logic [2:0] REG_VEL_KI        = 3'd4;
  localparam logic [2:0] REG_SCAN_VELOCITY = 3'd5;
  localparam logic [2:0] REG_EDGE_MARGIN   = 3'd6;
  localparam logic [2:0] REG_PAN_LIMIT     = 3'd7;

  // configuration reset values
  localparam logic [7:0]  RST_MAX_SPEED     = 8'd220;
  localparam logic [5:0]  RST_POS_KP        = 6'd7;
  localparam logic [5:0]  RST_POS_KD        = 6'd4;
  localparam logic [5:0]  RST_VEL_KP        = 6'd10;
  localparam logic [5:0]  RST_VEL_KI        = 6'd2;
  localparam logic [5:0]  RST_SCAN_VELOCITY = 6'd8;
  localparam logic [11:0] RST_EDGE_MARGIN   = 12'd200;
  localparam logic [13:0] RST_PAN_LIMIT     = 14'd4764;

  // term widths feeding the drive units
  localparam int A_W = 18;   // error / velocity error term
  localparam int B_W = 23;   // derivative * 10 / integral term

  // loop constants
  localparam logic signed [16:0] TILT_LOW       = -17'sd524;
  localparam logic signed [16:0] SCAN_WINDOW    = 17'sd20;
  localparam logic signed [9:0]  INTEGRAL_LIMIT = 10'sd100;
  localparam logic signed [9:0]  VEL_MAX        = 10'sd127;
  localparam logic signed [9:0]  VEL_MIN        = -10'sd128;

  // divide by ten: floor(x * 52429 / 2^19) is exact for x below 2^18
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    logic                  scan;
    logic signed [A_W-1:0] pan_a;
    logic signed [B_W-1:0] pan_b;
    logic signed [A_W-1:0] tilt_a;
    logic signed [B_W-1:0] tilt_b;
  } terms_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pan_tilt_pd_with_scan_pi.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pan_tilt_pd_with_scan_pi
// Pan/tilt motor drive controller: PD position loops with a PI pan sweep.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns one result item
// per input item; each item passes the input register (loaded at the
// accepting edge), the loop-term register (where all loop state is updated)
// and the result register. The whole pipeline advances together whenever
// the result register is empty or being taken, so in_stall simply mirrors a
// held result (out_valid with out_stall). Each item clamps the pan reference
// to +-pan_limit and the tilt reference to -524..0.
// When the clamped pan reference lies within 20 counts of either limit and
// fire_seen is low, pan runs the PI velocity sweep (velocity = position delta
// / 10, truncated toward zero, integral held within +-100 and cleared at each
// edge turn) and scanning is set; otherwise pan runs the PD position loop.
// Tilt always runs PD. Both drives saturate at max_speed and come out as a
// magnitude and a direction bit. Write configuration through cfg_we /
// cfg_index / cfg_data only while no item is in flight; reset restores the
// documented register defaults and clears the loop state.
// ----------------------------------------------------------------------------
module pan_tilt_pd_with_scan_pi (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [13:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_pan_reference,
  input  wire logic signed [15:0] in_tilt_reference,
  input  wire logic signed [15:0] in_pan_position,
  input  wire logic signed [15:0] in_tilt_position,
  input  wire logic               in_fire_seen,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_pan_magnitude,
  output logic                    out_pan_forward,
  output logic [7:0]              out_tilt_magnitude,
  output logic                    out_tilt_forward,
  output logic                    out_scanning
);
  import ptscan_pkg::*;

  // configuration registers
  logic [7:0]  max_speed_r;
  logic [5:0]  pos_kp_r, pos_kd_r, vel_kp_r, vel_ki_r, scan_velocity_r;
  logic [11:0] edge_margin_r;
  logic [13:0] pan_limit_r;

  // pipeline
  logic               adv;
  logic               in_vld_r, term_vld_r, out_vld_r;
  logic signed [15:0] pref_r, tref_r, ppos_r, tpos_r;
  logic               fire_r;
  terms_t             terms_nxt, terms_r;

  logic [5:0]  pan_ga, pan_gb;
  logic [7:0]  pan_mag, tilt_mag;
  logic        pan_fwd, tilt_fwd;
  logic [7:0]  pan_mag_r, tilt_mag_r;
  logic        pan_fwd_r, tilt_fwd_r, scan_r;

  // advance everything unless a finished item is held at the output
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r     <= RST_MAX_SPEED;
      pos_kp_r        <= RST_POS_KP;
      pos_kd_r        <= RST_POS_KD;
      vel_kp_r        <= RST_VEL_KP;
      vel_ki_r        <= RST_VEL_KI;
      scan_velocity_r <= RST_SCAN_VELOCITY;
      edge_margin_r   <= RST_EDGE_MARGIN;
      pan_limit_r     <= RST_PAN_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_SPEED:     max_speed_r     <= cfg_data[7:0];
        REG_POS_KP:        pos_kp_r        <= cfg_data[5:0];
        REG_POS_KD:        pos_kd_r        <= cfg_data[5:0];
        REG_VEL_KP:        vel_kp_r        <= cfg_data[5:0];
        REG_VEL_KI:        vel_ki_r        <= cfg_data[5:0];
        REG_SCAN_VELOCITY: scan_velocity_r <= cfg_data[5:0];
        REG_EDGE_MARGIN:   edge_margin_r   <= cfg_data[11:0];
        REG_PAN_LIMIT:     pan_limit_r     <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      term_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (adv) begin
      in_vld_r   <= in_valid;
      term_vld_r <= in_vld_r;
      out_vld_r  <= term_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      pref_r     <= in_pan_reference;
      tref_r     <= in_tilt_reference;
      ppos_r     <= in_pan_position;
      tpos_r     <= in_tilt_position;
      fire_r     <= in_fire_seen;
      terms_r    <= terms_nxt;
      pan_mag_r  <= pan_mag;
      pan_fwd_r  <= pan_fwd;
      tilt_mag_r <= tilt_mag;
      tilt_fwd_r <= tilt_fwd;
      scan_r     <= terms_r.scan;
    end
  end

  // stage 1: clamps, errors, velocity; loop state steps only on a real item
  ptscan_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (adv && in_vld_r),
    .pan_reference  (pref_r),
    .tilt_reference (tref_r),
    .pan_position   (ppos_r),
    .tilt_position  (tpos_r),
    .fire_seen      (fire_r),
    .scan_velocity  (scan_velocity_r),
    .edge_margin    (edge_margin_r),
    .pan_limit      (pan_limit_r),
    .terms          (terms_nxt)
  );

  // stage 2: gain products and saturation
  assign pan_ga = terms_r.scan ? vel_kp_r : pos_kp_r;
  assign pan_gb = terms_r.scan ? vel_ki_r : pos_kd_r;

  // pan forward is a positive drive, tilt forward a negative one
  ptscan_drive u_pan_drive (
    .a         (terms_r.pan_a),
    .b         (terms_r.pan_b),
    .ga        (pan_ga),
    .gb        (pan_gb),
    .max_speed (max_speed_r),
    .neg_dir   (1'b0),
    .magnitude (pan_mag),
    .forward   (pan_fwd)
  );

  ptscan_drive u_tilt_drive (
    .a         (terms_r.tilt_a),
    .b         (terms_r.tilt_b),
    .ga        (pos_kp_r),
    .gb        (pos_kd_r),
    .max_speed (max_speed_r),
    .neg_dir   (1'b1),
    .magnitude (tilt_mag),
    .forward   (tilt_fwd)
  );

  assign out_valid          = out_vld_r;
  assign out_pan_magnitude  = pan_mag_r;
  assign out_pan_forward    = pan_fwd_r;
  assign out_tilt_magnitude = tilt_mag_r;
  assign out_tilt_forward   = tilt_fwd_r;
  assign out_scanning       = scan_r;

endmodule
`default_nettype wire

// ----- hw/rtl/ptscan_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptscan_front
// Reference clamping, mode select, errors, sweep velocity and loop state.
// ----------------------------------------------------------------------------
module ptscan_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic signed [15:0] pan_reference,
  input  wire logic signed [15:0] tilt_reference,
  input  wire logic signed [15:0] pan_position,
  input  wire logic signed [15:0] tilt_position,
  input  wire logic               fire_seen,
  input  wire logic [5:0]         scan_velocity,
  input  wire logic [11:0]        edge_margin,
  input  wire logic [13:0]        pan_limit,
  output ptscan_pkg::terms_t      terms
);
  import ptscan_pkg::*;

  logic signed [17:0] last_pan_err_r, last_pan_err_nxt;
  logic signed [17:0] last_tilt_err_r, last_tilt_err_nxt;
  logic signed [15:0] prev_pan_pos_r, prev_pan_pos_nxt;
  logic signed [7:0]  integ_r, integ_nxt;
  logic               toward_max_r, toward_max_nxt;

  logic signed [16:0] lim_s, window, edge_pt;
  logic signed [16:0] pref_x, pref_c, tref_x, tref_c, ppos_x;
  logic               scan;
  logic signed [17:0] pan_err, tilt_err;
  logic signed [18:0] pan_dlt, tilt_dlt;
  logic signed [22:0] pan_d10, tilt_d10;
  logic signed [16:0] vdiff;
  logic               vneg;
  logic [16:0]        vmag;
  logic [33:0]        vprod;
  logic [14:0]        vq;
  logic signed [9:0]  vel, want, verr_w, verr, isum, integ_new;

  always_comb begin
    lim_s   = signed'({3'b000, pan_limit});
    window  = lim_s - SCAN_WINDOW;
    edge_pt = lim_s - signed'({5'b00000, edge_margin});

    // clamp references
    pref_x = {pan_reference[15], pan_reference};
    if (pref_x < -lim_s) begin
      pref_c = -lim_s;
    end else if (pref_x > lim_s) begin
      pref_c = lim_s;
    end else begin
      pref_c = pref_x;
    end
    tref_x = {tilt_reference[15], tilt_reference};
    if (tref_x > 17'sd0) begin
      tref_c = 17'sd0;
    end else if (tref_x < TILT_LOW) begin
      tref_c = TILT_LOW;
    end else begin
      tref_c = tref_x;
    end
    ppos_x = {pan_position[15], pan_position};

    scan = ((pref_c >= window) || (pref_c <= -window)) && !fire_seen;

    // position errors and derivative terms (delta * 10 as shift-add)
    pan_err  = {pref_c[16], pref_c} - {{2{pan_position[15]}}, pan_position};
    tilt_err = {tref_c[16], tref_c} - {{2{tilt_position[15]}}, tilt_position};
    pan_dlt  = {pan_err[17], pan_err} - {last_pan_err_r[17], last_pan_err_r};
    tilt_dlt = {tilt_err[17], tilt_err} - {last_tilt_err_r[17], last_tilt_err_r};
    pan_d10  = {pan_dlt[18], pan_dlt, 3'b000} + {{3{pan_dlt[18]}}, pan_dlt, 1'b0};
    tilt_d10 = {tilt_dlt[18], tilt_dlt, 3'b000} + {{3{tilt_dlt[18]}}, tilt_dlt, 1'b0};

    // sweep velocity, truncated toward zero
    vdiff = ppos_x - {prev_pan_pos_r[15], prev_pan_pos_r};
    vneg  = vdiff[16];
    vmag  = vneg ? unsigned'(-vdiff) : unsigned'(vdiff);
    vprod = {17'd0, vmag} * {17'd0, DIV10_MUL};
    vq    = vprod[DIV10_SHIFT +: 15];
    if (vneg) begin
      vel = (vq > 15'd128) ? VEL_MIN : -signed'({1'b0, vq[8:0]});
    end else begin
      vel = (vq > 15'd127) ? VEL_MAX : signed'({3'b000, vq[6:0]});
    end
    want   = toward_max_r ? signed'({4'b0000, scan_velocity})
                          : -signed'({4'b0000, scan_velocity});
    verr_w = want - vel;
    if (verr_w > VEL_MAX) begin
      verr = VEL_MAX;
    end else if (verr_w < VEL_MIN) begin
      verr = VEL_MIN;
    end else begin
      verr = verr_w;
    end
    isum = {{2{integ_r[7]}}, integ_r} + verr;
    if (isum > INTEGRAL_LIMIT) begin
      integ_new = INTEGRAL_LIMIT;
    end else if (isum < -INTEGRAL_LIMIT) begin
      integ_new = -INTEGRAL_LIMIT;
    end else begin
      integ_new = isum;
    end

    // state update
    last_pan_err_nxt  = last_pan_err_r;
    last_tilt_err_nxt = tilt_err;
    prev_pan_pos_nxt  = prev_pan_pos_r;
    integ_nxt         = integ_r;
    toward_max_nxt    = toward_max_r;
    if (scan) begin
      prev_pan_pos_nxt = pan_position;
      if (ppos_x >= edge_pt) begin
        toward_max_nxt = 1'b0;
        integ_nxt      = 8'sd0;
      end else if (ppos_x <= -edge_pt) begin
        toward_max_nxt = 1'b1;
        integ_nxt      = 8'sd0;
      end else begin
        integ_nxt = integ_new[7:0];
      end
    end else begin
      last_pan_err_nxt = pan_err;
    end

    // terms for the drive units
    terms.scan   = scan;
    terms.tilt_a = tilt_err;
    terms.tilt_b = tilt_d10;
    if (scan) begin
      terms.pan_a = {{8{verr[9]}}, verr};
      terms.pan_b = {{13{integ_new[9]}}, integ_new};
    end else begin
      terms.pan_a = pan_err;
      terms.pan_b = pan_d10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pan_err_r  <= '0;
      last_tilt_err_r <= '0;
      prev_pan_pos_r  <= '0;
      integ_r         <= '0;
      toward_max_r    <= 1'b1;
    end else if (step) begin
      last_pan_err_r  <= last_pan_err_nxt;
      last_tilt_err_r <= last_tilt_err_nxt;
      prev_pan_pos_r  <= prev_pan_pos_nxt;
      integ_r         <= integ_nxt;
      toward_max_r    <= toward_max_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ptscan_drive.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptscan_drive
// Two-term gain sum with saturation to the drive limit.
// ----------------------------------------------------------------------------
module ptscan_drive (
  input  wire logic signed [ptscan_pkg::A_W-1:0] a,
  input  wire logic signed [ptscan_pkg::B_W-1:0] b,
  input  wire logic [5:0]                         ga,
  input  wire logic [5:0]                         gb,
  input  wire logic [7:0]                         max_speed,
  input  wire logic                               neg_dir,
  output logic [7:0]                              magnitude,
  output logic                                    forward
);
  import ptscan_pkg::*;

  logic signed [6:0]       ga_s, gb_s;
  logic signed [A_W+6:0]   pa;
  logic signed [B_W+6:0]   pb;
  logic signed [31:0]      sum;
  logic [31:0]             mag_w;
  logic                    live;

  always_comb begin
    ga_s  = signed'({1'b0, ga});
    gb_s  = signed'({1'b0, gb});
    pa    = a * ga_s;
    pb    = b * gb_s;
    sum   = {{(32-A_W-7){pa[A_W+6]}}, pa} + {{(32-B_W-7){pb[B_W+6]}}, pb};
    mag_w = sum[31] ? unsigned'(-sum) : unsigned'(sum);
    // saturate magnitude; a zero limit forces a zero drive
    magnitude = (mag_w > {24'd0, max_speed}) ? max_speed : mag_w[7:0];
    live      = (max_speed != 8'd0);
    // forward means a negative drive when neg_dir is set, else a positive one
    if (neg_dir) begin
      forward = sum[31] && live;
    end else begin
      forward = !sum[31] && (sum != 32'sd0) && live;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pan/tilt drive controller. A queue-fed driver
// offers control ticks, a monitor predicts each accepted tick's drive values
// from its own copy of the loop state and checks every result in order. The
// run walks through several register settings and idle patterns on both
// channels, including a long output hold and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import ptscan_pkg::*;

  localparam int  VEL_DIV     = 10;      // position delta per tick -> velocity
  localparam int  DERIV_GAIN  = 10;      // error delta scale in the D term
  localparam int  LONG_HOLD   = 300;     // cycles of forced output stall
  localparam int  DRAIN_TAIL  = 4;       // pipeline depth plus one
  localparam int  CYCLE_LIMIT = 250000;

  // one control tick as offered on the input channel
  typedef struct {
    logic signed [15:0] pan_ref;
    logic signed [15:0] tilt_ref;
    logic signed [15:0] pan_pos;
    logic signed [15:0] tilt_pos;
    logic               fire;
  } tick_t;

  // one drive result, in port order
  typedef struct packed {
    logic [7:0] pan_mag;
    logic       pan_fwd;
    logic [7:0] tilt_mag;
    logic       tilt_fwd;
    logic       scan;
  } drive_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_MAX_SPEED;
  logic [13:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_pan_reference = '0;
  logic signed [15:0] in_tilt_reference = '0;
  logic signed [15:0] in_pan_position = '0;
  logic signed [15:0] in_tilt_position = '0;
  logic               in_fire_seen = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_pan_magnitude;
  logic               out_pan_forward;
  logic [7:0]         out_tilt_magnitude;
  logic               out_tilt_forward;
  logic               out_scanning;

  pan_tilt_pd_with_scan_pi u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pan_reference  (in_pan_reference),
    .in_tilt_reference (in_tilt_reference),
    .in_pan_position   (in_pan_position),
    .in_tilt_position  (in_tilt_position),
    .in_fire_seen      (in_fire_seen),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pan_magnitude (out_pan_magnitude),
    .out_pan_forward   (out_pan_forward),
    .out_tilt_magnitude(out_tilt_magnitude),
    .out_tilt_forward  (out_tilt_forward),
    .out_scanning      (out_scanning)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench-side copy of the register file and of the loop state
  // --------------------------------------------------------------------------
  logic [7:0]  cur_max_speed     = RST_MAX_SPEED;
  logic [5:0]  cur_pos_kp        = RST_POS_KP;
  logic [5:0]  cur_pos_kd        = RST_POS_KD;
  logic [5:0]  cur_vel_kp        = RST_VEL_KP;
  logic [5:0]  cur_vel_ki        = RST_VEL_KI;
  logic [5:0]  cur_scan_velocity = RST_SCAN_VELOCITY;
  logic [11:0] cur_edge_margin   = RST_EDGE_MARGIN;
  logic [13:0] cur_pan_limit     = RST_PAN_LIMIT;

  logic signed [17:0] pan_err_prev  = '0;   // touched only by the PD pan loop
  logic signed [17:0] tilt_err_prev = '0;
  logic signed [15:0] pan_pos_prev  = '0;   // touched only by the sweep loop
  logic signed [7:0]  vel_integ     = '0;
  logic               sweep_up      = 1'b1;

  // --------------------------------------------------------------------------
  // Bench bookkeeping
  // --------------------------------------------------------------------------
  tick_t  pending_ticks[$];     // ticks waiting for the driver
  drive_t drive_pred[$];        // predicted drives, oldest first
  bit     item_taken = 1'b0;    // input handshake seen at the last rising edge
  int     src_idle_pct = 0;
  int     sink_idle_pct = 0;
  bit     hold_request = 1'b0;
  int     hold_left = 0;
  int     mismatches = 0;
  int     items_taken = 0;
  int     results_checked = 0;
  int     sweep_results = 0;
  int     settings_used = 1;
  int     cycle_count = 0;
  int     sweep_walk = 0;       // random-walk pan position for sweep runs
  int     walk_dir = 1;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // PD position loop: P on the error, D on ten times the error delta
  function automatic longint pd_drive(longint err, longint prior, longint kp,
                                      longint kd, longint ms);
    return clip(err * kp + (err - prior) * DERIV_GAIN * kd, -ms, ms);
  endfunction

  // Work out the drive result of one accepted tick and advance the loop state.
  function automatic drive_t predict_drive(tick_t t);
    drive_t r;
    longint lim, ms, kp, kd, vkp, vki, sweep_v, margin;
    longint pref, tref, ppos, tpos, vel, want, verr, integ, turn_at;
    longint pan_d, tilt_d;
    logic   scan;
    lim = cur_pan_limit;   ms = cur_max_speed;
    kp = cur_pos_kp;       kd = cur_pos_kd;
    vkp = cur_vel_kp;      vki = cur_vel_ki;
    sweep_v = cur_scan_velocity;
    margin = cur_edge_margin;
    pref = t.pan_ref;  tref = t.tilt_ref;
    ppos = t.pan_pos;  tpos = t.tilt_pos;

    pref = clip(pref, -lim, lim);
    tref = clip(tref, TILT_LOW, 0);
    // signed window compares, still applied when the limit is below the window
    scan = (pref >= lim - SCAN_WINDOW || pref <= SCAN_WINDOW - lim) && !t.fire;

    if (scan) begin
      // division truncates toward zero; narrowings saturate
      vel = clip((ppos - pan_pos_prev) / VEL_DIV, VEL_MIN, VEL_MAX);
      want = sweep_up ? sweep_v : -sweep_v;
      verr = clip(want - vel, VEL_MIN, VEL_MAX);
      integ = clip(vel_integ + verr, -INTEGRAL_LIMIT, INTEGRAL_LIMIT);
      pan_d = clip(verr * vkp + integ * vki, -ms, ms);
      // turn at the edges after the drive; the upper edge wins a tie
      turn_at = lim - margin;
      if (ppos >= turn_at) begin
        sweep_up = 1'b0;
        integ = 0;
      end else if (ppos <= -turn_at) begin
        sweep_up = 1'b1;
        integ = 0;
      end
      vel_integ = 8'(integ);
      pan_pos_prev = 16'(ppos);
    end else begin
      pan_d = pd_drive(pref - ppos, pan_err_prev, kp, kd, ms);
      pan_err_prev = 18'(pref - ppos);
    end

    tilt_d = pd_drive(tref - tpos, tilt_err_prev, kp, kd, ms);
    tilt_err_prev = 18'(tref - tpos);

    r.pan_mag  = 8'(pan_d < 0 ? -pan_d : pan_d);
    r.pan_fwd  = pan_d > 0;
    r.tilt_mag = 8'(tilt_d < 0 ? -tilt_d : tilt_d);
    r.tilt_fwd = tilt_d < 0;
    r.scan     = scan;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer the next pending tick, hold it until taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drv
    tick_t nxt;
    if (!in_valid || item_taken) begin
      if (rst_n && pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_ticks.pop_front();
        in_valid          <= 1'b1;
        in_pan_reference  <= nxt.pan_ref;
        in_tilt_reference <= nxt.tilt_ref;
        in_pan_position   <= nxt.pan_pos;
        in_tilt_position  <= nxt.tilt_pos;
        in_fire_seen      <= nxt.fire;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the result taken at this edge, then predict the tick taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    drive_t got, want;
    tick_t  seen;
    if (!rst_n) begin
      item_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_pan_magnitude, out_pan_forward, out_tilt_magnitude,
               out_tilt_forward, out_scanning};
        if (drive_pred.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result at cycle %0d: pan %0d/%0b tilt %0d/%0b scan %0b",
                     cycle_count, got.pan_mag, got.pan_fwd, got.tilt_mag,
                     got.tilt_fwd, got.scan);
        end else begin
          want = drive_pred.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch on result %0d (cycle %0d):", results_checked, cycle_count);
              $display("  expected pan %0d fwd %0b tilt %0d fwd %0b scan %0b",
                       want.pan_mag, want.pan_fwd, want.tilt_mag, want.tilt_fwd, want.scan);
              $display("  actual   pan %0d fwd %0b tilt %0d fwd %0b scan %0b",
                       got.pan_mag, got.pan_fwd, got.tilt_mag, got.tilt_fwd, got.scan);
            end
          end
        end
        results_checked++;
      end
      item_taken = in_valid && !in_stall;
      if (item_taken) begin
        seen = '{in_pan_reference, in_tilt_reference, in_pan_position,
                 in_tilt_position, in_fire_seen};
        want = predict_drive(seen);
        if (want.scan) sweep_results++;
        drive_pred.push_back(want);
        items_taken++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, drive_pred.size());
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_tick(int pr, int tr, int pp, int tp, bit f);
    tick_t t;
    t.pan_ref  = 16'(pr);
    t.tilt_ref = 16'(tr);
    t.pan_pos  = 16'(pp);
    t.tilt_pos = 16'(tp);
    t.fire     = f;
    pending_ticks.push_back(t);
  endtask

  // Write one register at a falling edge and mirror it in the bench copy.
  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 14'(val);
    case (idx)
      REG_MAX_SPEED:     cur_max_speed     = 8'(val);
      REG_POS_KP:        cur_pos_kp        = 6'(val);
      REG_POS_KD:        cur_pos_kd        = 6'(val);
      REG_VEL_KP:        cur_vel_kp        = 6'(val);
      REG_VEL_KI:        cur_vel_ki        = 6'(val);
      REG_SCAN_VELOCITY: cur_scan_velocity = 6'(val);
      REG_EDGE_MARGIN:   cur_edge_margin   = 12'(val);
      REG_PAN_LIMIT:     cur_pan_limit     = 14'(val);
      default: ;
    endcase
  endtask

  task automatic apply_settings(int ms, int kp, int kd, int vkp, int vki,
                                int sweep_v, int margin, int lim);
    write_reg(REG_MAX_SPEED, ms);
    write_reg(REG_POS_KP, kp);
    write_reg(REG_POS_KD, kd);
    write_reg(REG_VEL_KP, vkp);
    write_reg(REG_VEL_KI, vki);
    write_reg(REG_SCAN_VELOCITY, sweep_v);
    write_reg(REG_EDGE_MARGIN, margin);
    write_reg(REG_PAN_LIMIT, lim);
    @(negedge clk) cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Block until every tick has been taken and every result has come back.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid || drive_pred.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Random ticks, mostly sweep runs with a walking pan position so the
  // velocity loop sees realistic deltas and bounces between the edges; the
  // rest are PD runs near the reference and full-range noise.
  task automatic queue_random(int count);
    int lim, span, kind, run, pr, tr, pp, tp, sgn;
    bit f;
    lim = cur_pan_limit;
    span = (lim > 300) ? lim : 300;
    while (count > 0) begin
      kind = $urandom_range(9);
      run = (kind <= 5) ? $urandom_range(5, 30) :
            (kind <= 7) ? $urandom_range(3, 15) : $urandom_range(1, 4);
      for (int k = 0; k < run && count > 0; k++) begin
        sgn = $urandom_range(1) ? 1 : -1;
        if (kind <= 5) begin
          // advance the walk; jump now and then
          if ($urandom_range(19) == 0)
            sweep_walk = int'($urandom_range(0, 2 * span)) - span;
          else
            sweep_walk += walk_dir * (int'($urandom_range(0, 160)) - 20);
          if (sweep_walk >= span) walk_dir = -1;
          if (sweep_walk <= -span) walk_dir = 1;
          pp = sweep_walk;
          pr = ($urandom_range(3) == 0) ? sgn * (lim - int'($urandom_range(0, 25)))
                                        : sgn * (lim + int'($urandom_range(0, 50)));
          f = ($urandom_range(15) == 0);
        end else if (kind <= 7) begin
          pr = int'($urandom_range(0, 2 * lim)) - lim;
          pp = pr + int'($urandom_range(0, 600)) - 300;
          f = 1'($urandom_range(1));
        end else begin
          pr = int'($urandom_range(0, 65535)) - 32768;
          pp = int'($urandom_range(0, 65535)) - 32768;
          f = 1'($urandom_range(1));
        end
        if ($urandom_range(3) == 0) begin
          tr = int'($urandom_range(0, 65535)) - 32768;
          tp = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          tr = int'($urandom_range(0, 600)) - 560;
          tp = tr + int'($urandom_range(0, 800)) - 400;
        end
        queue_tick(pr, tr, pp, tp, f);
        count--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver mostly stalling
    src_idle_pct  = 6;
    sink_idle_pct = 84;

    // Directed ticks under reset settings (limit 4764, window 4744, turn 4564)
    queue_tick(0, -300, 0, 0, 0);                      // plain PD on both axes
    queue_tick(32767, 32767, 32767, 32767, 1);         // top extremes, fire blocks sweep
    queue_tick(-32768, -32768, -32768, -32768, 1);     // bottom extremes
    queue_tick(4744, -100, 100, -50, 0);               // exactly on the window: sweep
    queue_tick(4743, -100, 100, -50, 0);               // one inside: PD
    queue_tick(-4744, 0, 85, 0, 0);                    // negative window, delta -15 truncates
    queue_tick(32767, 0, 32767, 0, 0);                 // velocity saturates high, turn down
    queue_tick(-32768, 0, -32768, 0, 0);               // velocity saturates low, turn up
    queue_tick(32767, 0, 32767, 0, 0);                 // velocity saturates high again, turn down
    queue_tick(32767, 0, -32768, 0, 0);
    queue_tick(32767, 0, -32768, 0, 0);                // zero velocity at the lower edge, integral cleared
    queue_tick(4764, 0, -32700, 0, 0);
    queue_tick(4764, 0, -32600, 0, 0);
    queue_tick(4764, 0, 4500, 0, 0);                   // below the turn point
    queue_tick(4764, 0, 4563, 0, 0);
    queue_tick(4764, 0, 4564, 0, 0);                   // exactly at the turn point
    queue_tick(-4764, 0, -4564, 0, 0);                 // exactly at the lower turn point
    queue_tick(4764, 0, 4600, 0, 1);                   // fire: back to PD, big D term
    queue_tick(100, 0, -524, 0, 1);                    // tilt reference at the upper bound
    queue_tick(100, -524, 0, 0, 1);                    // tilt drive negative
    queue_tick(100, 1, 0, 0, 1);                       // tilt reference above range
    queue_tick(100, -525, 0, 0, 1);                    // tilt reference below range
    queue_tick(4764, -300, -32768, -32768, 1);         // pan saturates positive
    queue_tick(-4764, -300, 32767, 32767, 1);          // pan saturates negative
    queue_tick(-4764, -300, -4764, -300, 1);           // zero error after a big one
    queue_random(160);
    wait_drained();

    // Everything at its minimum: zero limit makes every unfired tick sweep
    apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
    queue_random(130);
    wait_drained();

    // Everything at its maximum
    apply_settings(255, 63, 63, 63, 63, 63, 4095, 16383);
    queue_random(160);
    wait_drained();

    // Swap: sender mostly idle, receiver mostly ready
    src_idle_pct  = 84;
    sink_idle_pct = 6;

    // Limit below the window, margin above the limit: both turn tests hold
    apply_settings($urandom_range(255), $urandom_range(63), $urandom_range(63),
                   $urandom_range(63), $urandom_range(63), $urandom_range(63), 200, 5);
    queue_random(160);
    wait_drained();

    // Random settings, sender pauses for a full drain between bursts
    apply_settings($urandom_range(255), $urandom_range(63), $urandom_range(63),
                   $urandom_range(63), $urandom_range(63), $urandom_range(63),
                   $urandom_range(1500), $urandom_range(100, 9000));
    repeat (4) begin
      queue_random(45);
      wait_drained();
    end

    // No idling on either side from here on
    src_idle_pct  = 0;
    sink_idle_pct = 0;

    // Back to reset values; hold the output long enough to back up the input
    apply_settings(RST_MAX_SPEED, RST_POS_KP, RST_POS_KD, RST_VEL_KP, RST_VEL_KI,
                   RST_SCAN_VELOCITY, RST_EDGE_MARGIN, RST_PAN_LIMIT);
    hold_request = 1'b1;
    queue_random(170);
    wait_drained();

    apply_settings($urandom_range(255), $urandom_range(63), $urandom_range(63),
                   $urandom_range(63), $urandom_range(63), $urandom_range(63),
                   $urandom_range(4095), $urandom_range(16383));
    queue_random(170);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("Covered %0d ticks over %0d register settings, %0d results checked",
             items_taken, settings_used, results_checked);
    $display("%0d results from the sweep loop, %0d mismatches",
             sweep_results, mismatches);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
